[src/swc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swc_pkg
// Types, width codes and helper functions shared by the slot width converter.
// ----------------------------------------------------------------------------
package swc_pkg;

	localparam logic [3:0] WC_U8  = 4'd0;
	localparam logic [3:0] WC_U16 = 4'd1;
	localparam logic [3:0] WC_U32 = 4'd2;
	localparam logic [3:0] WC_U64 = 4'd3;
	localparam logic [3:0] WC_I8  = 4'd4;
	localparam logic [3:0] WC_I16 = 4'd5;
	localparam logic [3:0] WC_I32 = 4'd6;
	localparam logic [3:0] WC_I64 = 4'd7;
	localparam logic [3:0] WC_F32 = 4'd8;
	localparam logic [3:0] WC_F64 = 4'd9;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef enum logic [2:0] {
		CLS_PASS,
		CLS_RD_INT,
		CLS_RD_F32,
		CLS_WR_INT,
		CLS_WR_F32
	} cls_t;

	// Byte size of a slot; zero marks an undefined width code
	function automatic logic [3:0] slot_bytes(input logic [3:0] wc);
		logic [3:0] b;
		unique case (wc)
			WC_U8, WC_I8:             b = 4'd1;
			WC_U16, WC_I16:           b = 4'd2;
			WC_U32, WC_I32, WC_F32:   b = 4'd4;
			WC_U64, WC_I64, WC_F64:   b = 4'd8;
			default:                  b = 4'd0;
		endcase
		return b;
	endfunction

	// Mask over the low bytes of a slot
	function automatic logic [63:0] low_mask(input logic [3:0] bytes);
		logic [63:0] m;
		if (bytes >= 4'd8) begin
			m = '1;
		end else begin
			m = (64'd1 << {bytes, 3'b000}) - 64'd1;
		end
		return m;
	endfunction

	// Leading zeros of a nonzero word
	function automatic logic [5:0] lzc64(input logic [63:0] x);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) n = 6'(63 - i);
		end
		return n;
	endfunction

endpackage

[src/swc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swc_if
// Request and response channels of the slot width converter.
// ----------------------------------------------------------------------------
interface swc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  width_code;
	logic [63:0] slot_bits;
	logic [63:0] value_bits;

	modport source (output valid, req_type, width_code, slot_bits, value_bits, input ready);
	modport sink   (input valid, req_type, width_code, slot_bits, value_bits, output ready);
endinterface

interface swc_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_bits;
	logic [3:0]  result_bytes;

	modport source (output valid, result_bits, result_bytes, input ready);
	modport sink   (input valid, result_bits, result_bytes, output ready);
endinterface

[src/slot_width_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_width_converter
// Converts typed slot bytes to IEEE double bits (read) and double bits to
// saturated integer, rounded f32 or unchanged f64 slot bytes (write).
// ----------------------------------------------------------------------------
// Pipeline: three registered stages (decode, shift, round).
// Throughput: one request per cycle; the three stages advance together and
// hold while the response waits for ready.
// Reset: arst_n clears the stage valid bits only; no state spans requests.
// ----------------------------------------------------------------------------
module slot_width_converter
	import swc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	swc_req_if.sink     req,
	swc_rsp_if.source   rsp
);

	logic advance;

	// Stage 1 registers
	logic        v_s1;
	cls_t        cls_s1;
	logic        sign_s1;
	logic        sgn_tgt_s1;
	logic [63:0] word_s1;
	logic [3:0]  bytes_s1;

	// Stage 2 registers
	logic        v_s2;
	cls_t        cls_s2;
	logic        sign_s2;
	logic        up_s2;
	logic [63:0] word_s2;
	logic [3:0]  bytes_s2;

	// Stage 3 registers (response)
	logic        v_s3;
	cls_t        cls_s3;
	logic [63:0] res_s3;
	logic [3:0]  bytes_s3;

	assign advance   = !v_s3 || rsp.ready;
	assign req.ready = advance;

	// ---------------- Stage 1: decode and extract ----------------
	cls_t        cls_d1;
	logic        sign_d1;
	logic        sgn_tgt_d1;
	logic [63:0] word_d1;
	logic [3:0]  bytes_d1;
	logic [63:0] mask_d1;
	logic [63:0] raw_d1;
	logic [63:0] sext_d1;
	logic        sb_d1;

	always_comb begin
		bytes_d1   = slot_bytes(req.width_code);
		mask_d1    = low_mask(bytes_d1);
		raw_d1     = req.slot_bits & mask_d1;
		sb_d1      = raw_d1[6'({bytes_d1, 3'b000} - 7'd1)];
		sext_d1    = sb_d1 ? (raw_d1 | ~mask_d1) : raw_d1;
		cls_d1     = CLS_PASS;
		sign_d1    = 1'b0;
		sgn_tgt_d1 = 1'b0;
		word_d1    = 64'd0;
		if (bytes_d1 != 4'd0) begin
			if (req.req_type == REQ_READ) begin
				if (req.width_code <= WC_U64) begin
					cls_d1  = CLS_RD_INT;
					word_d1 = raw_d1;
				end else if (req.width_code <= WC_I64) begin
					cls_d1  = CLS_RD_INT;
					sign_d1 = sext_d1[63];
					word_d1 = sext_d1[63] ? (64'd0 - sext_d1) : sext_d1;
				end else if (req.width_code == WC_F32) begin
					cls_d1  = CLS_RD_F32;
					word_d1 = raw_d1;
				end else begin
					word_d1 = raw_d1;
				end
			end else begin
				word_d1 = req.value_bits;
				if (req.width_code <= WC_I64) begin
					cls_d1     = CLS_WR_INT;
					sgn_tgt_d1 = (req.width_code > WC_U64);
				end else if (req.width_code == WC_F32) begin
					cls_d1 = CLS_WR_F32;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s1     <= cls_d1;
			sign_s1    <= sign_d1;
			sgn_tgt_s1 <= sgn_tgt_d1;
			word_s1    <= word_d1;
			bytes_s1   <= bytes_d1;
		end
	end

	// ---------------- Stage 2: normalize and shift ----------------
	cls_t        cls_d2;
	logic        sign_d2;
	logic        up_d2;
	logic [63:0] word_d2;
	logic [5:0]  lz_d2;
	logic [63:0] norm_d2;
	logic [10:0] exp_d2;
	logic [51:0] frac_d2;
	logic [52:0] m53_d2;
	logic        nan_d2;
	logic [63:0] trunc_d2;
	logic [7:0]  fexp_d2;
	logic [22:0] fm_d2;
	logic [5:0]  flz_d2;
	logic [51:0] fnorm_d2;
	logic [11:0] sh_d2;
	logic [116:0] wide_d2;
	logic        lsb_d2;
	logic        rnd_d2;
	logic        stk_d2;

	always_comb begin
		cls_d2   = cls_s1;
		sign_d2  = sign_s1;
		up_d2    = 1'b0;
		word_d2  = word_s1;
		lz_d2    = lzc64(word_s1);
		norm_d2  = word_s1 << lz_d2;
		exp_d2   = word_s1[62:52];
		frac_d2  = word_s1[51:0];
		m53_d2   = {exp_d2 != 11'd0, frac_d2};
		nan_d2   = (exp_d2 == 11'h7FF) && (frac_d2 != 52'd0);
		fexp_d2  = word_s1[30:23];
		fm_d2    = word_s1[22:0];
		flz_d2   = lzc64({fm_d2, 41'd0});
		fnorm_d2 = {fm_d2, 29'd0} << (flz_d2 + 6'd1);
		trunc_d2 = 64'd0;
		sh_d2    = 12'd926 - {1'b0, exp_d2};
		if (sh_d2 > 12'd63) sh_d2 = 12'd63;
		wide_d2  = {m53_d2, 64'd0} >> sh_d2[5:0];
		lsb_d2   = 1'b0;
		rnd_d2   = 1'b0;
		stk_d2   = 1'b0;

		unique case (cls_s1)
			CLS_RD_INT: begin
				// Pack exponent and top mantissa, round up in stage 3
				if (word_s1 == 64'd0) begin
					word_d2 = 64'd0;
				end else begin
					word_d2 = {1'b0, 11'(11'd1086 - {5'd0, lz_d2}), norm_d2[62:11]};
					up_d2   = norm_d2[10] && (norm_d2[11] || (norm_d2[9:0] != 10'd0));
				end
			end
			CLS_RD_F32: begin
				cls_d2  = CLS_PASS;
				sign_d2 = 1'b0;
				if (fexp_d2 == 8'hFF) begin
					if (fm_d2 != 23'd0) begin
						word_d2 = {word_s1[31], 11'h7FF, {fm_d2, 29'd0} | (52'd1 << 51)};
					end else begin
						word_d2 = {word_s1[31], 11'h7FF, 52'd0};
					end
				end else if (fexp_d2 == 8'd0) begin
					if (fm_d2 == 23'd0) begin
						word_d2 = {word_s1[31], 63'd0};
					end else begin
						word_d2 = {word_s1[31], 11'(11'd896 - {5'd0, flz_d2}), fnorm_d2};
					end
				end else begin
					word_d2 = {word_s1[31], 11'({3'd0, fexp_d2} + 11'd896), fm_d2, 29'd0};
				end
			end
			CLS_WR_INT: begin
				// Truncate toward zero, then saturate
				if (exp_d2 < 11'd1023) begin
					trunc_d2 = 64'd0;
				end else if (exp_d2 >= 11'd1075) begin
					trunc_d2 = {11'd0, m53_d2} << ((exp_d2 <= 11'd1086) ?
						6'(exp_d2 - 11'd1075) : 6'd0);
				end else begin
					trunc_d2 = {11'd0, m53_d2} >> 6'(11'd1075 - exp_d2);
				end
				sign_d2 = 1'b0;
				if (nan_d2) begin
					word_d2 = 64'd0;
				end else if (sgn_tgt_s1 || word_s1[63]) begin
					if (exp_d2 >= 11'd1086) begin
						word_d2 = word_s1[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					end else begin
						word_d2 = trunc_d2;
						sign_d2 = word_s1[63];
					end
				end else begin
					word_d2 = (exp_d2 >= 11'd1087) ? '1 : trunc_d2;
				end
			end
			CLS_WR_F32: begin
				sign_d2 = word_s1[63];
				if (nan_d2) begin
					cls_d2  = CLS_PASS;
					word_d2 = {32'd0, word_s1[63], 8'hFF, frac_d2[51:29] | 23'h400000};
				end else if (exp_d2 == 11'h7FF) begin
					cls_d2  = CLS_PASS;
					word_d2 = {32'd0, word_s1[63], 8'hFF, 23'd0};
				end else if ((exp_d2 > 11'd1150) ||
					((exp_d2 == 11'd1150) && (frac_d2 > {{23{1'b1}}, 29'd0}))) begin
					// Clamp finite overflow to the largest f32
					cls_d2  = CLS_PASS;
					word_d2 = {32'd0, word_s1[63], 8'hFE, {23{1'b1}}};
				end else if (exp_d2 >= 11'd897) begin
					word_d2 = {33'd0, 8'(exp_d2 - 11'd896), frac_d2[51:29]};
					lsb_d2  = frac_d2[29];
					rnd_d2  = frac_d2[28];
					stk_d2  = (frac_d2[27:0] != 28'd0);
					up_d2   = rnd_d2 && (lsb_d2 || stk_d2);
				end else begin
					// Subnormal or zero result
					word_d2 = {41'd0, wide_d2[86:64]};
					lsb_d2  = wide_d2[64];
					rnd_d2  = wide_d2[63];
					stk_d2  = (wide_d2[62:0] != 63'd0);
					up_d2   = rnd_d2 && (lsb_d2 || stk_d2);
				end
			end
			default: begin
				word_d2 = word_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s2   <= cls_d2;
			sign_s2  <= sign_d2;
			up_s2    <= up_d2;
			word_s2  <= word_d2;
			bytes_s2 <= bytes_s1;
		end
	end

	// ---------------- Stage 3: round, negate, mask ----------------
	logic [63:0] res_d3;
	logic [63:0] neg_d3;

	always_comb begin
		neg_d3 = sign_s2 ? (64'd0 - word_s2) : word_s2;
		unique case (cls_s2)
			CLS_RD_INT: res_d3 = {sign_s2, word_s2[62:0] + {62'd0, up_s2}};
			CLS_WR_INT: res_d3 = neg_d3 & low_mask(bytes_s2);
			CLS_WR_F32: res_d3 = {32'd0, sign_s2, word_s2[30:0] + {30'd0, up_s2}};
			default:    res_d3 = word_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s3   <= cls_s2;
			res_s3   <= res_d3;
			bytes_s3 <= bytes_s2;
		end
	end

	assign rsp.valid        = v_s3;
	assign rsp.result_bits  = res_s3;
	assign rsp.result_bytes = bytes_s3;

	// ---------------- Assertions ----------------
	a_bytes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (bytes_s3 == 4'd0 || bytes_s3 == 4'd1 || bytes_s3 == 4'd2 ||
			bytes_s3 == 4'd4 || bytes_s3 == 4'd8))
		else $error("illegal slot byte count");

	a_f32_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && cls_s3 == CLS_WR_F32) |-> (res_s3[63:32] == 32'd0))
		else $error("f32 write leaves upper bytes set");

	a_int_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && cls_s3 == CLS_WR_INT) |-> ((res_s3 & ~low_mask(bytes_s3)) == 64'd0))
		else $error("integer write leaves bytes above the slot");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && advance) |=> v_s3)
		else $error("request dropped between stages");

endmodule

[tb/swc_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swc_tb_if
// Response record that the testbench keeps for the request and response channels.
// ----------------------------------------------------------------------------
// The channel interfaces come from the RTL source set (swc_req_if and
// swc_rsp_if). This file only holds the response record that the testbench
// keeps for each accepted request.
package swc_tb_pkg;

	typedef struct packed {
		logic [63:0] bits;
		logic [3:0]  bytes;
	} slot_result_t;

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the slot width converter.
// ----------------------------------------------------------------------------
// Drives read and write requests over every width code, predicts each
// converted slot or double in plain bit arithmetic, and compares every
// response in order. Directed corner cases come first, then random requests
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import swc_pkg::*;
	import swc_tb_pkg::*;

	localparam logic [3:0] WC_BAD = 4'd15;

	localparam logic [63:0] DBL_QNAN    = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] DBL_SNAN    = 64'hFFF0_0000_DEAD_BEEF;
	localparam logic [63:0] DBL_INF     = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] DBL_NINF    = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] DBL_FLT_MAX = 64'h47EF_FFFF_E000_0000;
	localparam logic [63:0] DBL_MAX     = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam int          RANDOM_PER_PHASE = 382;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   failures;

	slot_result_t pending_results[$];

	swc_req_if req_if();
	swc_rsp_if rsp_if();

	slot_width_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Bit-level conversion model
	// ------------------------------------------------------------------
	function automatic int top_bit(input logic [63:0] x);
		int p;
		p = 0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) p = i;
		end
		return p;
	endfunction

	// Shift right by sh (1..63 useful), rounding to nearest even
	function automatic logic [63:0] shift_rne(input logic [63:0] m, input int sh);
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		if (sh >= 64) return 64'd0;
		q    = m >> sh;
		rem  = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0])) q = q + 64'd1;
		return q;
	endfunction

	function automatic logic [63:0] int_to_double(input logic [63:0] mag, input logic neg);
		int          p;
		logic [63:0] mant;
		if (mag == 64'd0) return 64'd0;
		p = top_bit(mag);
		if (p <= 52) begin
			mant = mag << (52 - p);
		end else begin
			mant = shift_rne(mag, p - 52);
		end
		// hidden bit carries into the exponent, including a rounding overflow
		return {neg, 63'd0} | ((64'(1022 + p) << 52) + mant);
	endfunction

	// Truncate toward zero with 64-bit saturation
	function automatic logic [63:0] double_to_int(input logic [63:0] vb, input logic as_signed);
		logic        s;
		int          ex;
		logic [63:0] m;
		logic [63:0] mag;
		s  = vb[63];
		ex = int'(vb[62:52]) - 1023;
		if (vb[62:52] == 11'h7FF && vb[51:0] != 52'd0) return 64'd0;
		if (s) as_signed = 1'b1;
		if (as_signed && ex >= 63) return s ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (!as_signed && ex >= 64) return '1;
		if (ex < 0) return 64'd0;
		m   = {11'd0, 1'b1, vb[51:0]};
		mag = (ex >= 52) ? (m << (ex - 52)) : (m >> (52 - ex));
		return s ? -mag : mag;
	endfunction

	function automatic logic [63:0] double_to_f32(input logic [63:0] vb);
		logic        s;
		int          ex;
		int          sh;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] base;
		s  = vb[63];
		ex = int'(vb[62:52]) - 1023;
		if (vb[62:52] == 11'h7FF && vb[51:0] != 52'd0)
			return {32'd0, s, 31'h7FC0_0000 | 31'(vb[51:29])};
		if (vb[62:52] == 11'h7FF) return {32'd0, s, 31'h7F80_0000};
		// clamp finite values beyond the f32 range
		if (vb[62:0] > DBL_FLT_MAX[62:0]) return {32'd0, s, 31'h7F7F_FFFF};
		if (vb[62:52] == 11'd0) return {32'd0, s, 31'd0};
		m = {11'd0, 1'b1, vb[51:0]};
		if (ex >= -126) begin
			sh   = 29;
			base = 64'(ex + 126) << 23;
		end else begin
			sh   = 29 + (-126 - ex);
			base = 64'd0;
		end
		q = base + shift_rne(m, sh);
		return {32'd0, s, q[30:0]};
	endfunction

	function automatic logic [63:0] f32_to_double(input logic [31:0] fb);
		int p;
		if (fb[30:23] == 8'hFF && fb[22:0] != 23'd0)
			return {fb[31], 11'h7FF, 1'b1, 51'd0} | (64'(fb[22:0]) << 29);
		if (fb[30:23] == 8'hFF) return {fb[31], 11'h7FF, 52'd0};
		if (fb[30:23] == 8'd0) begin
			if (fb[22:0] == 23'd0) return {fb[31], 63'd0};
			// subnormal: normalize the fraction
			p = top_bit(64'(fb[22:0]));
			return {fb[31], 11'(p - 149 + 1023), 52'((64'(fb[22:0]) << (52 - p)))};
		end
		return {fb[31], 11'(int'(fb[30:23]) - 127 + 1023), fb[22:0], 29'd0};
	endfunction

	function automatic logic [3:0] width_bytes(input logic [3:0] wc);
		case (wc)
			WC_U8, WC_I8:           return 4'd1;
			WC_U16, WC_I16:         return 4'd2;
			WC_U32, WC_I32, WC_F32: return 4'd4;
			WC_U64, WC_I64, WC_F64: return 4'd8;
			default:                return 4'd0;
		endcase
	endfunction

	function automatic slot_result_t convert_slot(input logic rt, input logic [3:0] wc,
			input logic [63:0] sb, input logic [63:0] vb);
		slot_result_t r;
		logic [63:0]  mask;
		logic [63:0]  raw;
		r.bytes = width_bytes(wc);
		r.bits  = 64'd0;
		mask = (r.bytes == 4'd8) ? '1 : ((64'd1 << (8 * r.bytes)) - 64'd1);
		if (r.bytes == 4'd0) return r;
		if (rt == REQ_READ) begin
			raw = sb & mask;
			if (wc <= WC_U64) begin
				r.bits = int_to_double(raw, 1'b0);
			end else if (wc <= WC_I64) begin
				if (raw[8 * r.bytes - 1]) raw = raw | ~mask;
				r.bits = int_to_double(raw[63] ? -raw : raw, raw[63]);
			end else if (wc == WC_F32) begin
				r.bits = f32_to_double(raw[31:0]);
			end else begin
				r.bits = raw;
			end
		end else begin
			if (wc <= WC_U64) begin
				r.bits = double_to_int(vb, 1'b0) & mask;
			end else if (wc <= WC_I64) begin
				r.bits = double_to_int(vb, 1'b1) & mask;
			end else if (wc == WC_F32) begin
				r.bits = double_to_f32(vb);
			end else begin
				r.bits = vb;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request driver and response checker
	// ------------------------------------------------------------------
	task automatic send_request(input logic rt, input logic [3:0] wc,
			input logic [63:0] sb, input logic [63:0] vb);
		int gap;
		// hold off for a random gap in the idle phases
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(4, 1);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.req_type   <= rt;
		req_if.width_code <= wc;
		req_if.slot_bits  <= sb;
		req_if.value_bits <= vb;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
		pending_results.push_back(convert_slot(rt, wc, sb, vb));
	endtask

	// Stall the response side
	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each response with the oldest expected one
	always @(posedge clk) begin
		slot_result_t exp_r;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response bits=%h bytes=%0d", $time,
					rsp_if.result_bits, rsp_if.result_bytes);
				failures++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_if.result_bits !== exp_r.bits) begin
					$display("%0t: result_bits expected %h actual %h", $time,
						exp_r.bits, rsp_if.result_bits);
					failures++;
				end
				if (rsp_if.result_bytes !== exp_r.bytes) begin
					$display("%0t: result_bytes expected %0d actual %0d", $time,
						exp_r.bytes, rsp_if.result_bytes);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_double();
		logic [63:0] v;
		v = rand64();
		case ($urandom_range(7))
			0: ; // raw bits
			1: v[62:52] = 11'(1023 + $urandom_range(70));       // integer range
			2: v[62:52] = 11'(1023 + $urandom_range(20));
			3: v[62:52] = 11'(1147 + $urandom_range(6));        // f32 range edge
			4: v[62:52] = 11'(1023 - 155 + $urandom_range(40)); // f32 subnormals
			5: v[62:52] = 11'(1023 - $urandom_range(3));
			6: begin
				case ($urandom_range(5))
					0: v = DBL_QNAN | (v & 64'h8007_FFFF_FFFF_FFFF);
					1: v = {v[63], DBL_INF[62:0]};
					2: v = {v[63], 63'd0};
					3: v = {v[63], DBL_FLT_MAX[62:0] + 63'($urandom_range(2)) - 63'd1};
					4: v = {v[63], DBL_MAX[62:0]};
					default: v = {v[63], 11'(1023 + 63 + $urandom_range(1)), 52'd0};
				endcase
			end
			default: v[62:52] = 11'(1023 + 52 + $urandom_range(12));
		endcase
		return v;
	endfunction

	function automatic logic [63:0] rand_slot();
		logic [63:0] s;
		s = rand64();
		case ($urandom_range(5))
			0: s[30:23] = 8'hFF;                      // f32 inf / NaN
			1: s[30:23] = 8'h00;                      // f32 zero / subnormal
			2: s[31:0]  = {s[31], 31'h7FFF_FFFF} ^ 32'(s[63]);
			default: ;
		endcase
		return s;
	endfunction

	task automatic test_directed();
		send_request(REQ_READ,  WC_U8,  64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_request(REQ_READ,  WC_I8,  64'h1234_5678_9ABC_DE80, 64'd0);
		send_request(REQ_READ,  WC_I16, 64'h0000_0000_0000_7FFF, 64'd0);
		send_request(REQ_READ,  WC_I32, 64'hFFFF_FFFF_8000_0000, 64'd0);
		send_request(REQ_READ,  WC_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_request(REQ_READ,  WC_U64, 64'h0020_0000_0000_0001, 64'd0);
		send_request(REQ_READ,  WC_I64, 64'h8000_0000_0000_0000, 64'd0);
		send_request(REQ_READ,  WC_F32, 64'hAAAA_AAAA_FFC0_0001, 64'd0);
		send_request(REQ_READ,  WC_F32, 64'h0000_0000_0000_0001, 64'd0);
		send_request(REQ_READ,  WC_F32, 64'h0000_0000_FF80_0000, 64'd0);
		send_request(REQ_READ,  WC_F64, 64'hFFF0_0000_0000_0001, 64'd0);
		send_request(REQ_WRITE, WC_U32, 64'd0, DBL_SNAN);
		send_request(REQ_WRITE, WC_F32, 64'd0, DBL_SNAN);
		send_request(REQ_WRITE, WC_F64, 64'd0, DBL_SNAN);
		send_request(REQ_WRITE, WC_F32, 64'd0, DBL_NINF);
		send_request(REQ_WRITE, WC_U8,  64'd0, DBL_NINF);
		send_request(REQ_WRITE, WC_F32, 64'd0, DBL_MAX);
		send_request(REQ_WRITE, WC_F32, 64'd0, 64'h0000_0000_0000_0001);
		send_request(REQ_WRITE, WC_I64, 64'd0, 64'hC3E0_0000_0000_0000);  // -2^63
		send_request(REQ_WRITE, WC_U64, 64'd0, 64'h43F0_0000_0000_0000);  // 2^64
		send_request(REQ_WRITE, WC_U32, 64'd0, 64'hBFF8_0000_0000_0000);  // -1.5
		send_request(REQ_WRITE, WC_I16, 64'd0, 64'h40E0_0000_0000_0000);  // 32768
		send_request(REQ_READ,  WC_BAD, '1, '1);
		send_request(REQ_WRITE, 4'd10,  '1, '1);
	endtask

	task automatic test_random(input int count);
		logic [3:0] wc;
		for (int i = 0; i < count; i++) begin
			wc = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
			                               : 4'($urandom_range(9));
			send_request(1'($urandom_range(1)), wc, rand_slot(), rand_double());
		end
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		failures  = 0;
		idle_pct  = 0;
		stall_pct = 0;
		req_if.valid      = 1'b0;
		req_if.req_type   = REQ_READ;
		req_if.width_code = WC_U8;
		req_if.slot_bits  = 64'd0;
		req_if.value_bits = 64'd0;
		rsp_if.ready      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(RANDOM_PER_PHASE);
		idle_pct = 47;
		test_random(RANDOM_PER_PHASE);
		// pause until every response is back
		wait_drained();
		idle_pct  = 0;
		stall_pct = 47;
		test_random(RANDOM_PER_PHASE);
		idle_pct  = 24;
		stall_pct = 24;
		test_random(RANDOM_PER_PHASE);

		wait_drained();
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
src/swc_pkg.sv
src/swc_if.sv
src/slot_width_converter.sv
tb/swc_tb_if.sv
tb/tb_top.sv
